// ===== rtl/core/video_controller_register_decode_core_macros.svh =====
// Assertion helpers shared by the register decode RTL.
// Each macro takes a label, the clock, the active-low reset, the two
// expressions of the property and a message string.
`ifndef VIDEO_CONTROLLER_REGISTER_DECODE_CORE_MACROS_SVH
`define VIDEO_CONTROLLER_REGISTER_DECODE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define VCRD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VCRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define VCRD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define VCRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/vcrd_pkg.sv =====
package vcrd_pkg;

    // Field widths of the transactions.
    localparam int PORT_W = 16;
    localparam int DATA_W = 8;

    // Access kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Array sizes.
    localparam int EXT_REG_COUNT_DEF = 128;
    localparam int CRTC_DEPTH        = 25;
    localparam int CRTC_AW           = $clog2(CRTC_DEPTH);

    // Fixed values.
    localparam logic [7:0]  GLOBAL_ID      = 8'hA5;
    localparam logic [7:0]  UNMAPPED_DATA  = 8'hFF;
    localparam logic [5:0]  CRTC_LAST      = 6'h18;
    localparam logic [15:0] ALIAS_XOR      = 16'h0060;
    localparam logic [7:0]  EXT_INDEX_MASK = 8'h7F;
    localparam logic [7:0]  CRTC_IDX_MASK  = 8'h3F;
    localparam logic [7:0]  CR07_KEEP_MASK = 8'hEF;
    localparam logic [7:0]  CR07_WR_MASK   = 8'h10;

    // Decoded port addresses.
    localparam logic [15:0] PORT_SLEEP      = 16'h0102;
    localparam logic [15:0] PORT_EXT_ENABLE = 16'h0103;
    localparam logic [15:0] PORT_GLOBAL_ID  = 16'h0104;
    localparam logic [15:0] PORT_CRTC_INDEX = 16'h03D4;
    localparam logic [15:0] PORT_CRTC_DATA  = 16'h03D5;
    localparam logic [15:0] PORT_EXT_INDEX  = 16'h03D6;
    localparam logic [15:0] PORT_EXT_DATA   = 16'h03D7;
    localparam logic [15:0] PORT_SETUP      = 16'h46E8;
    localparam logic [15:0] PORT_EXT_MONO   = 16'h03B6;
    localparam logic [15:0] PORT_COLOR_PAGE = 16'h03D0;
    localparam logic [15:0] PORT_MONO_PAGE  = 16'h03B0;
    localparam logic [7:0]  PAGE_3XX        = 8'h03;

    // CRTC and extension register indexes with special handling.
    localparam logic [5:0] CRTC_OVERFLOW   = 6'h07;
    localparam logic [5:0] CRTC_VRET_END   = 6'h11;
    localparam logic [5:0] CRTC_TIMING_GAP_LO = 6'h0E;
    localparam logic [5:0] CRTC_TIMING_GAP_HI = 6'h10;
    localparam logic [6:0] XR_PROTECT      = 7'h15;

    // Power-on values of the extension registers.
    function automatic logic [7:0] ext_reset_value(input logic [6:0] idx);
        logic [7:0] v;
        unique case (idx)
            7'h00:   v = 8'h04;
            7'h01:   v = 8'h5A;
            7'h28:   v = 8'h02;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/vcrd_if.sv =====
// Command channel: one I/O access.
interface vcrd_cmd_if
    import vcrd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [PORT_W-1:0] port;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output kind, output port, output write_data, input ready);
    modport sink   (input valid, input kind, input port, input write_data, output ready);
endinterface

// Response channel: the outcome of one access.
interface vcrd_rsp_if
    import vcrd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              forwarded;
    logic              timing_changed;

    modport source (output valid, output read_data, output forwarded,
                    output timing_changed, input ready);
    modport sink   (input valid, input read_data, input forwarded,
                    input timing_changed, output ready);
endinterface

// ===== rtl/core/video_controller_register_decode_core.sv =====
// A transaction is latched on acceptance; its response is registered when it is decoded and written back.
// The block takes no new transaction until the last one is through; the extension and CRTC arrays sit in
// synchronous memories with one read port, read at acceptance and written back in the decode state.
// A full response register stalls the write-back cycle until the response is taken.
// Reset clears all control registers and the valid bits of both arrays at once; entries not
// yet written read as their power-on values, so no clearing pass is needed.
`include "video_controller_register_decode_core_macros.svh"

module video_controller_register_decode_core
    import vcrd_pkg::*;
#(
    parameter int EXT_REG_COUNT = EXT_REG_COUNT_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    vcrd_cmd_if.sink   cmd,
    vcrd_rsp_if.source rsp
);

    localparam int EXT_AW = $clog2(EXT_REG_COUNT);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // Sequencer and latched command.
    logic              state_reg, state_next;
    logic              kind_reg;
    logic [PORT_W-1:0] port_reg;
    logic [DATA_W-1:0] wdata_reg;

    // Scalar registers.
    logic       color_mode_reg;
    logic [7:0] sleep_reg;
    logic [7:0] ext_enable_reg;
    logic [6:0] ext_index_reg;
    logic [7:0] setup_ctrl_reg;
    logic [5:0] crtc_index_reg;
    logic       crtc11_b7_reg;
    logic       xr15_b6_reg;

    // Memories, their valid bits and registered read data.
    logic [7:0]               ext_mem [EXT_REG_COUNT];
    logic [7:0]               crtc_mem [CRTC_DEPTH];
    logic [EXT_REG_COUNT-1:0] ext_valid_reg;
    logic [CRTC_DEPTH-1:0]    crtc_valid_reg;
    logic [7:0]               ext_q_reg;
    logic [7:0]               crtc_q_reg;
    logic                     ext_q_valid_reg;
    logic                     crtc_q_valid_reg;

    // Response register.
    logic       rsp_valid_reg;
    logic [7:0] rsp_read_data_reg;
    logic       rsp_forwarded_reg;
    logic       rsp_timing_reg;

    logic              cmd_fire;
    logic              exec_go;
    logic [EXT_AW-1:0] ext_addr;
    logic [CRTC_AW-1:0] crtc_addr;
    logic              ext_in_range;
    logic              crtc_in_range;
    logic [7:0]        ext_old;
    logic [7:0]        crtc_old;
    logic              protect;
    logic              gated;
    logic [PORT_W-1:0] dport;
    logic              wr;

    // Decode results.
    logic [7:0] rd_c;
    logic       fwd_c;
    logic       tchg_c;
    logic       sleep_we_c, ext_enable_we_c, ext_index_we_c, setup_we_c, crtc_index_we_c;
    logic       ext_we_c, crtc_we_c;
    logic [7:0] crtc_nv_c;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign exec_go   = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    assign ext_addr      = ext_index_reg[EXT_AW-1:0];
    assign crtc_addr     = crtc_index_reg[CRTC_AW-1:0];
    assign ext_in_range  = ({1'b0, ext_index_reg} < 8'(EXT_REG_COUNT));
    assign crtc_in_range = (crtc_index_reg <= CRTC_LAST);

    // Entries never written read as their power-on values.
    assign ext_old  = ext_q_valid_reg ? ext_q_reg : ext_reset_value(ext_index_reg);
    assign crtc_old = crtc_q_valid_reg ? crtc_q_reg : 8'h00;
    assign protect  = crtc11_b7_reg || xr15_b6_reg;
    assign wr       = (kind_reg == KIND_WRITE);

    // Sequencer: accept, then decode and write back once the response slot is free.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (cmd_fire) state_next = S_EXEC;
            S_EXEC:  if (exec_go)  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Page gating and port aliasing.
    always_comb
    begin
        gated = !setup_ctrl_reg[3] && (port_reg[15:8] == PAGE_3XX);
        dport = port_reg;
        if (((port_reg & 16'hFFFE) == PORT_EXT_INDEX) || ((port_reg & 16'hFFFE) == PORT_EXT_MONO))
        begin
            if (ext_enable_reg[6])
            begin
                dport = port_reg ^ ALIAS_XOR;
            end
        end
        else if ((((port_reg & 16'hFFF0) == PORT_COLOR_PAGE) ||
                  ((port_reg & 16'hFFF0) == PORT_MONO_PAGE)) && !color_mode_reg)
        begin
            dport = port_reg ^ ALIAS_XOR;
        end
    end

    // Register decode for the latched access.
    always_comb
    begin
        rd_c            = UNMAPPED_DATA;
        fwd_c           = 1'b0;
        tchg_c          = 1'b0;
        sleep_we_c      = 1'b0;
        ext_enable_we_c = 1'b0;
        ext_index_we_c  = 1'b0;
        setup_we_c      = 1'b0;
        crtc_index_we_c = 1'b0;
        ext_we_c        = 1'b0;
        crtc_we_c       = 1'b0;
        crtc_nv_c       = wdata_reg;
        if (!gated)
        begin
            unique case (dport)
                PORT_SLEEP:
                begin
                    if (wr) sleep_we_c = 1'b1;
                    else    rd_c = sleep_reg;
                end
                PORT_EXT_ENABLE:
                begin
                    if (setup_ctrl_reg[4])
                    begin
                        if (wr) ext_enable_we_c = 1'b1;
                        else    rd_c = ext_enable_reg;
                    end
                end
                PORT_GLOBAL_ID:
                begin
                    if (!wr) rd_c = GLOBAL_ID;
                end
                PORT_CRTC_INDEX:
                begin
                    if (wr) crtc_index_we_c = 1'b1;
                    else    rd_c = {2'b00, crtc_index_reg};
                end
                PORT_CRTC_DATA:
                begin
                    if (crtc_in_range)
                    begin
                        if (!wr)
                        begin
                            rd_c = crtc_old;
                        end
                        else if (!(protect && (crtc_index_reg < CRTC_OVERFLOW)))
                        begin
                            // Under protection CR07 keeps all bits but bit 4.
                            if (protect && (crtc_index_reg == CRTC_OVERFLOW))
                            begin
                                crtc_nv_c = (crtc_old & CR07_KEEP_MASK) |
                                            (wdata_reg & CR07_WR_MASK);
                            end
                            crtc_we_c = 1'b1;
                            tchg_c    = (crtc_old != crtc_nv_c) &&
                                        ((crtc_index_reg < CRTC_TIMING_GAP_LO) ||
                                         (crtc_index_reg > CRTC_TIMING_GAP_HI));
                        end
                    end
                end
                PORT_EXT_INDEX:
                begin
                    if (ext_enable_reg[7])
                    begin
                        if (wr) ext_index_we_c = 1'b1;
                        else    rd_c = {1'b0, ext_index_reg};
                    end
                end
                PORT_EXT_DATA:
                begin
                    if (ext_enable_reg[7] && ext_in_range)
                    begin
                        if (wr) ext_we_c = 1'b1;
                        else    rd_c = ext_old;
                    end
                end
                PORT_SETUP:
                begin
                    if (wr) setup_we_c = 1'b1;
                end
                default:
                begin
                    fwd_c = 1'b1;
                end
            endcase
        end
    end

    // Memory ports: read at acceptance, write back in the decode cycle.
    always_ff @(posedge clk)
    begin
        if (cmd_fire && ext_in_range)
        begin
            ext_q_reg <= ext_mem[ext_addr];
        end
        if (cmd_fire && crtc_in_range)
        begin
            crtc_q_reg <= crtc_mem[crtc_addr];
        end
        if (exec_go && ext_we_c)
        begin
            ext_mem[ext_addr] <= wdata_reg;
        end
        if (exec_go && crtc_we_c)
        begin
            crtc_mem[crtc_addr] <= crtc_nv_c;
        end
    end

    // Latched command payload.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            kind_reg  <= cmd.kind;
            port_reg  <= cmd.port;
            wdata_reg <= cmd.write_data;
        end
    end

    // Control state, scalar registers and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            color_mode_reg   <= 1'b0;
            sleep_reg        <= 8'h00;
            ext_enable_reg   <= 8'h00;
            ext_index_reg    <= 7'h00;
            setup_ctrl_reg   <= 8'h00;
            crtc_index_reg   <= 6'h00;
            crtc11_b7_reg    <= 1'b0;
            xr15_b6_reg      <= 1'b0;
            ext_valid_reg    <= '0;
            crtc_valid_reg   <= '0;
            ext_q_valid_reg  <= 1'b0;
            crtc_q_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                color_mode_reg <= cfg_wdata;
            end
            if (cmd_fire)
            begin
                ext_q_valid_reg  <= ext_in_range && ext_valid_reg[ext_addr];
                crtc_q_valid_reg <= crtc_in_range && crtc_valid_reg[crtc_addr];
            end
            if (exec_go)
            begin
                if (sleep_we_c)      sleep_reg      <= wdata_reg;
                if (ext_enable_we_c) ext_enable_reg <= wdata_reg;
                if (setup_we_c)      setup_ctrl_reg <= wdata_reg;
                if (ext_index_we_c)  ext_index_reg  <= 7'(wdata_reg & EXT_INDEX_MASK);
                if (crtc_index_we_c) crtc_index_reg <= 6'(wdata_reg & CRTC_IDX_MASK);
                if (ext_we_c)
                begin
                    ext_valid_reg[ext_addr] <= 1'b1;
                    if (ext_index_reg == XR_PROTECT) xr15_b6_reg <= wdata_reg[6];
                end
                if (crtc_we_c)
                begin
                    crtc_valid_reg[crtc_addr] <= 1'b1;
                    if (crtc_index_reg == CRTC_VRET_END) crtc11_b7_reg <= crtc_nv_c[7];
                end
            end
        end
    end

    // Response register handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (exec_go)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            rsp_read_data_reg <= wr ? 8'h00 : rd_c;
            rsp_forwarded_reg <= fwd_c;
            rsp_timing_reg    <= tchg_c;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.read_data      = rsp_read_data_reg;
    assign rsp.forwarded      = rsp_forwarded_reg;
    assign rsp.timing_changed = rsp_timing_reg;

    // Checks on the sequencing and the response encoding.
    `VCRD_ASSERT_NEXT(a_fire_to_exec, clk, rst_n, cmd_fire, state_reg == S_EXEC,
        "accepted transaction did not enter the decode cycle")
    `VCRD_ASSERT_NEXT(a_exec_to_rsp, clk, rst_n, exec_go,
        rsp_valid_reg && state_reg == S_IDLE,
        "decode cycle did not load the response register")
    `VCRD_ASSERT_IMPLIES(a_fwd_no_timing, clk, rst_n, rsp_valid_reg && rsp_forwarded_reg,
        !rsp_timing_reg, "forwarded transaction flagged a timing change")
    `VCRD_ASSERT_IMPLIES(a_timing_is_write, clk, rst_n, rsp_valid_reg && rsp_timing_reg,
        rsp_read_data_reg == 8'h00, "timing change reported with read data")

endmodule
